// File: rtl/mcmp_pkg.sv
// Shared types and constants for the MIDI channel message parser.
// No dependencies; read by the interface file and the top level.
`default_nettype none

package mcmp_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned DataW    = 7;
    localparam int unsigned NibbleW  = 4;
    localparam int unsigned KindW    = 3;
    localparam int unsigned KindN    = 7;
    localparam int unsigned FilterW  = 16;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 16;

    localparam logic [FilterW-1:0] FilterReset = 16'hFFFF;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] RegChannelFilter = 2'd0;
    localparam logic [CfgIdxW-1:0] RegThruEnable    = 2'd1;
    localparam logic [CfgIdxW-1:0] RegKindEnable    = 2'd2;

    // Command nibbles of status bytes
    localparam logic [NibbleW-1:0] CmdNoteOff  = 4'h8;
    localparam logic [NibbleW-1:0] CmdProgram  = 4'hC;
    localparam logic [NibbleW-1:0] CmdPressure = 4'hD;
    localparam logic [NibbleW-1:0] CmdSystem   = 4'hF;

    typedef enum logic [3:0] {
        PHASE_STATUS = 4'b0001,
        PHASE_DATA1  = 4'b0010,
        PHASE_DATA2  = 4'b0100,
        PHASE_DONE   = 4'b1000
    } phase_t;

endpackage

`default_nettype wire

// File: rtl/mcmp_if.sv
// Valid/ready channel interfaces for the MIDI channel message parser.
// Depends on mcmp_pkg for field widths.
`default_nettype none

interface mcmp_in_if;
    logic                         valid;
    logic                         ready;
    logic [mcmp_pkg::ByteW-1:0]   byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface mcmp_out_if;
    logic                         valid;
    logic                         ready;
    logic                         msg_valid;
    logic [mcmp_pkg::KindW-1:0]   msg_kind;
    logic [mcmp_pkg::NibbleW-1:0] msg_channel;
    logic [mcmp_pkg::DataW-1:0]   data_first;
    logic [mcmp_pkg::DataW-1:0]   data_second;
    logic                         thru_valid;
    logic [mcmp_pkg::ByteW-1:0]   thru_byte;

    modport source (output valid, output msg_valid, output msg_kind, output msg_channel,
                    output data_first, output data_second, output thru_valid,
                    output thru_byte, input ready);
    modport sink   (input valid, input msg_valid, input msg_kind, input msg_channel,
                    input data_first, input data_second, input thru_valid,
                    input thru_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/midi_channel_message_parser_top.sv
// MIDI channel message parser: one received byte in, one result item out, per cycle.
// A byte is taken every cycle while the result register is empty or being drained, and
// its result is shown in the next cycle; the parse state and the result register are
// the only stages, so throughput is one item per clock while out_ch.ready is high.
// There is no running status: after a message completes, data bytes are ignored
// until the next status byte. Depends on mcmp_pkg and the interfaces in mcmp_if.sv.
`default_nettype none

module midi_channel_message_parser_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [mcmp_pkg::CfgIdxW-1:0]    cfg_index,
    input  wire logic [mcmp_pkg::CfgDataW-1:0]   cfg_data,
    mcmp_in_if.sink                              in_ch,
    mcmp_out_if.source                           out_ch
);

    logic [mcmp_pkg::FilterW-1:0]  filter_reg;
    logic                          thru_en_reg;
    logic [mcmp_pkg::KindN-1:0]    kind_en_reg;

    mcmp_pkg::phase_t              phase_reg, phase_next;
    logic [mcmp_pkg::NibbleW-1:0]  cmd_reg, cmd_next;
    logic [mcmp_pkg::NibbleW-1:0]  chan_reg, chan_next;
    logic [mcmp_pkg::DataW-1:0]    first_reg, first_next;

    logic                          out_valid_reg;
    logic                          msg_valid_reg, msg_valid_next;
    logic [mcmp_pkg::KindW-1:0]    kind_reg, kind_next;
    logic [mcmp_pkg::NibbleW-1:0]  msg_chan_reg, msg_chan_next;
    logic [mcmp_pkg::DataW-1:0]    d1_reg, d1_next;
    logic [mcmp_pkg::DataW-1:0]    d2_reg, d2_next;
    logic                          thru_valid_reg, thru_valid_next;
    logic [mcmp_pkg::ByteW-1:0]    thru_byte_reg, thru_byte_next;

    logic                          accept;
    logic                          done;
    logic [mcmp_pkg::KindW-1:0]    kind;
    logic [mcmp_pkg::DataW-1:0]    d1, d2;
    logic [mcmp_pkg::DataW-1:0]    data;
    logic [mcmp_pkg::NibbleW-1:0]  byte_cmd, byte_chan;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    assign data      = in_ch.byte_in[mcmp_pkg::DataW-1:0];
    assign byte_cmd  = in_ch.byte_in[mcmp_pkg::ByteW-1:mcmp_pkg::NibbleW];
    assign byte_chan = in_ch.byte_in[mcmp_pkg::NibbleW-1:0];
    // Commands reaching a data phase are 0x8..0xE, so the kind is the command minus 0x8
    assign kind      = mcmp_pkg::KindW'(cmd_reg - mcmp_pkg::CmdNoteOff);

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_reg  <= mcmp_pkg::FilterReset;
            thru_en_reg <= 1'b0;
            kind_en_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mcmp_pkg::RegChannelFilter: filter_reg  <= cfg_data[mcmp_pkg::FilterW-1:0];
                mcmp_pkg::RegThruEnable:    thru_en_reg <= cfg_data[0];
                mcmp_pkg::RegKindEnable:    kind_en_reg <= cfg_data[mcmp_pkg::KindN-1:0];
                default: ;
            endcase
        end
    end

    // Parse step
    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        chan_next  = chan_reg;
        first_next = first_reg;
        done       = 1'b0;
        d1         = '0;
        d2         = '0;
        if (in_ch.byte_in[mcmp_pkg::ByteW-1])
        begin
            // Status byte restarts parsing, even on a blocked channel
            cmd_next  = byte_cmd;
            chan_next = byte_chan;
            if (filter_reg[byte_chan])
                phase_next = (byte_cmd == mcmp_pkg::CmdSystem) ? mcmp_pkg::PHASE_DONE
                                                                : mcmp_pkg::PHASE_DATA1;
            else
                phase_next = mcmp_pkg::PHASE_STATUS;
        end
        else
        begin
            unique case (phase_reg)
                mcmp_pkg::PHASE_DATA1:
                begin
                    first_next = data;
                    if (cmd_reg == mcmp_pkg::CmdProgram || cmd_reg == mcmp_pkg::CmdPressure)
                    begin
                        done       = 1'b1;
                        d1         = data;
                        phase_next = mcmp_pkg::PHASE_DONE;
                    end
                    else
                        phase_next = mcmp_pkg::PHASE_DATA2;
                end
                mcmp_pkg::PHASE_DATA2:
                begin
                    done       = 1'b1;
                    d1         = first_reg;
                    d2         = data;
                    phase_next = mcmp_pkg::PHASE_DONE;
                end
                default: ;  // awaiting status or done: drop the byte
            endcase
        end
    end

    always_comb
    begin
        msg_valid_next  = done && kind_en_reg[kind];
        kind_next       = msg_valid_next ? kind : '0;
        msg_chan_next   = msg_valid_next ? chan_reg : '0;
        d1_next         = msg_valid_next ? d1 : '0;
        d2_next         = msg_valid_next ? d2 : '0;
        thru_valid_next = thru_en_reg;
        thru_byte_next  = thru_en_reg ? in_ch.byte_in : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= mcmp_pkg::PHASE_STATUS;
            cmd_reg       <= '0;
            chan_reg      <= '0;
            first_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                cmd_reg   <= cmd_next;
                chan_reg  <= chan_next;
                first_reg <= first_next;
            end
            // Hold the result until taken; refill in the same cycle it drains
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            msg_valid_reg  <= msg_valid_next;
            kind_reg       <= kind_next;
            msg_chan_reg   <= msg_chan_next;
            d1_reg         <= d1_next;
            d2_reg         <= d2_next;
            thru_valid_reg <= thru_valid_next;
            thru_byte_reg  <= thru_byte_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.msg_valid   = msg_valid_reg;
    assign out_ch.msg_kind    = kind_reg;
    assign out_ch.msg_channel = msg_chan_reg;
    assign out_ch.data_first  = d1_reg;
    assign out_ch.data_second = d2_reg;
    assign out_ch.thru_valid  = thru_valid_reg;
    assign out_ch.thru_byte   = thru_byte_reg;

endmodule

`default_nettype wire
